[rtl/plist_pkg.sv]
// ----------------------------------------------------------------------------
// plist_pkg
// Shared sizes, codes and the cell control struct of the positional list.
// ----------------------------------------------------------------------------
package plist_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int POS_W      = 7;
    localparam int DATA_W     = 32;

    localparam logic [1:0] ACT_INSERT   = 2'd0;
    localparam logic [1:0] ACT_DELETE   = 2'd1;
    localparam logic [1:0] ACT_TRAVERSE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_ROTATE = 2'd3;

    typedef struct packed {
        logic [1:0]               op;
        logic [POS_W-1:0]         pos;
        logic [POS_W-1:0]         tail;
        logic signed [DATA_W-1:0] data;
    } plist_ctl_t;

endpackage

[rtl/plist_if.sv]
// ----------------------------------------------------------------------------
// plist_if
// Request and response channels of the positional list (valid/ready).
// ----------------------------------------------------------------------------
interface plist_req_if
    import plist_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [1:0]               action;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;

    modport source (output valid, action, value, position, input ready);
    modport sink   (input valid, action, value, position, output ready);
endinterface

interface plist_rsp_if
    import plist_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] element;
    logic                     last;

    modport source (output valid, status, element, last, input ready);
    modport sink   (input valid, status, element, last, output ready);
endinterface

[rtl/plist_cell.sv]
// ----------------------------------------------------------------------------
// plist_cell
// One list slot: holds a value and takes it from a neighbor on shift.
// ----------------------------------------------------------------------------
module plist_cell
    import plist_pkg::*;
(
    input  logic                     clk,
    input  plist_ctl_t               ctl,
    input  logic [IDX_W-1:0]         idx,
    input  logic signed [DATA_W-1:0] left_val,
    input  logic signed [DATA_W-1:0] right_val,
    input  logic signed [DATA_W-1:0] head_val,
    output logic signed [DATA_W-1:0] val
);

    logic signed [DATA_W-1:0] val_reg;
    logic signed [DATA_W-1:0] val_next;
    logic [POS_W-1:0]         my_pos;

    assign my_pos = POS_W'(idx);

    always_comb
    begin
        val_next = val_reg;
        case (ctl.op)
            OP_INSERT:
            begin
                if (my_pos > ctl.pos)
                    val_next = left_val;
                else if (my_pos == ctl.pos)
                    val_next = ctl.data;
            end
            OP_DELETE:
            begin
                if (my_pos >= ctl.pos)
                    val_next = right_val;
            end
            OP_ROTATE:
            begin
                // the tail slot wraps the head around
                if (my_pos == ctl.tail)
                    val_next = head_val;
                else
                    val_next = right_val;
            end
            default:
                val_next = val_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

[rtl/positional_list_insert_delete_top.sv]
// ----------------------------------------------------------------------------
// positional_list_insert_delete_top
// Ordered list of signed words with insert, delete and traverse by position.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command per beat: action (insert, delete, traverse),
//   value and a 1-based position. rsp returns status, element and last.
//   Insert and delete answer with one beat in the cycle after acceptance;
//   all slots shift together, so one such command is taken every cycle
//   while rsp drains. Traverse answers with count beats (one beat with
//   status empty on an empty list), one per cycle while rsp drains, taken
//   from the head slot while the slot chain rotates once around; req stays
//   blocked until the final beat is loaded.
//   An unused action code is taken and produces nothing.
//   A single output register holds the next beat; when rsp stalls, the
//   register holds, traversal pauses and req is not taken.
//   Reset empties the list at once; slot contents are not cleared.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_top
    import plist_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    plist_req_if.sink    req,
    plist_rsp_if.source  rsp
);

    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     busy_reg, busy_next;
    logic [CNT_W-1:0]         remain_reg, remain_next;
    logic                     out_valid_reg, out_valid_next;
    logic [1:0]               status_reg, status_next;
    logic signed [DATA_W-1:0] element_reg, element_next;
    logic                     last_reg, last_next;

    logic                     out_free;
    logic                     accept;
    logic                     emit;
    logic [POS_W-1:0]         count_ext;
    logic [1:0]               cmd_status;
    plist_ctl_t               ctl;
    logic signed [DATA_W-1:0] cell_val [LIST_DEPTH];

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = !busy_reg && out_free;
    assign accept    = req.valid && req.ready;
    assign emit      = busy_reg && out_free;
    assign count_ext = POS_W'(count_reg);

    always_comb
    begin
        cmd_status = ST_OK;
        if (req.action == ACT_INSERT)
        begin
            if (req.position == '0 || req.position > count_ext + POS_W'(1))
                cmd_status = ST_RANGE;
            else if (count_reg == CNT_W'(LIST_DEPTH))
                cmd_status = ST_FULL;
        end
        else
        begin
            if (count_reg == '0)
                cmd_status = ST_EMPTY;
            else if (req.position == '0 || req.position > count_ext)
                cmd_status = ST_RANGE;
        end
    end

    always_comb
    begin
        ctl.op   = OP_HOLD;
        ctl.pos  = req.position - POS_W'(1);
        ctl.tail = count_ext - POS_W'(1);
        ctl.data = req.value;

        count_next     = count_reg;
        busy_next      = busy_reg;
        remain_next    = remain_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        status_next    = status_reg;
        element_next   = element_reg;
        last_next      = last_reg;

        if (accept)
        begin
            case (req.action)
                ACT_INSERT, ACT_DELETE:
                begin
                    out_valid_next = 1'b1;
                    status_next    = cmd_status;
                    element_next   = '0;
                    last_next      = 1'b1;
                    if (cmd_status == ST_OK)
                    begin
                        if (req.action == ACT_INSERT)
                        begin
                            ctl.op     = OP_INSERT;
                            count_next = count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            ctl.op     = OP_DELETE;
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                end
                ACT_TRAVERSE:
                begin
                    if (count_reg == '0)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = ST_EMPTY;
                        element_next   = '0;
                        last_next      = 1'b1;
                    end
                    else
                    begin
                        busy_next   = 1'b1;
                        remain_next = count_reg;
                    end
                end
                default:
                begin
                    // drop unused action codes
                end
            endcase
        end
        else if (emit)
        begin
            // advance: head goes out, chain rotates by one
            ctl.op         = OP_ROTATE;
            out_valid_next = 1'b1;
            status_next    = ST_OK;
            element_next   = cell_val[0];
            last_next      = (remain_reg == CNT_W'(1));
            remain_next    = remain_reg - CNT_W'(1);
            if (remain_reg == CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < LIST_DEPTH; gi++)
        begin : g_cell
            logic signed [DATA_W-1:0] left_w;
            logic signed [DATA_W-1:0] right_w;

            if (gi == 0)
            begin : g_first
                assign left_w = ctl.data;
            end
            else
            begin : g_mid_l
                assign left_w = cell_val[gi-1];
            end

            if (gi == LIST_DEPTH - 1)
            begin : g_final
                assign right_w = cell_val[0];
            end
            else
            begin : g_mid_r
                assign right_w = cell_val[gi+1];
            end

            plist_cell u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .idx       (IDX_W'(gi)),
                .left_val  (left_w),
                .right_val (right_w),
                .head_val  (cell_val[0]),
                .val       (cell_val[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            busy_reg      <= 1'b0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            busy_reg      <= busy_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        element_reg <= element_next;
        last_reg    <= last_next;
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.status  = status_reg;
    assign rsp.element = element_reg;
    assign rsp.last    = last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(LIST_DEPTH))
        else $error("list count above depth");

    a_busy_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (count_reg != '0 && remain_reg != '0 && remain_reg <= count_reg))
        else $error("traversal running on bad count");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.action == ACT_INSERT && cmd_status == ST_OK)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow list");

    a_traverse_holds: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |=> $stable(count_reg))
        else $error("count changed during traversal");
`endif

endmodule
